@@ hw/rtl/spi_master_byte_shifter_top_assert.svh @@
// Assertion macros shared by the checker of the SPI master byte shifter.
`ifndef SPI_MASTER_BYTE_SHIFTER_TOP_ASSERT_SVH
`define SPI_MASTER_BYTE_SHIFTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPI_MBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spi_mbs: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPI_MBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spi_mbs: assertion failed");

// Next-cycle implication that is also checked during reset.
`define SPI_MBS_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spi_mbs: assertion failed");

`endif

@@ hw/rtl/spi_mbs_pkg.sv @@
// Types and constants shared by the SPI master byte shifter modules.
`timescale 1ns / 1ps

package spi_mbs_pkg;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_SELECT  = 2'd1,
        CMD_SHIFT   = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_POLARITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS = 2'd2;

    localparam logic [7:0] MSB_MASK       = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
    localparam logic [7:0] HALF_TICKS_RST = 8'd1;

    typedef struct packed {
        logic       polarity;
        logic       phase;
        logic [7:0] half_ticks;
    } cfg_t;

    // Polarity write seen by the engine so an idle SCK follows it at once.
    typedef struct packed {
        logic wr;
        logic level;
    } pol_upd_t;

    typedef struct packed {
        cmd_t       mode;
        logic [7:0] tx_byte;
        logic       drive_out;
        logic       miso;
    } tick_in_t;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       cs_n;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       busy_res;
    } tick_res_t;

endpackage

@@ hw/rtl/spi_mbs_cfg.sv @@
// Configuration registers of the SPI master byte shifter.
`timescale 1ns / 1ps

module spi_mbs_cfg
    import spi_mbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg,
    output pol_upd_t              pol_upd
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_POLARITY:   cfg_next.polarity   = cfg_wdata[0];
                REG_PHASE:      cfg_next.phase      = cfg_wdata[0];
                REG_HALF_TICKS: cfg_next.half_ticks = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polarity   <= 1'b0;
            cfg_reg.phase      <= 1'b0;
            cfg_reg.half_ticks <= HALF_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg         = cfg_reg;
    assign pol_upd.wr    = cfg_we && (cfg_index == REG_POLARITY);
    assign pol_upd.level = cfg_wdata[0];

endmodule

@@ hw/rtl/spi_mbs_engine.sv @@
// Line state and one-tick update logic of the SPI master byte shifter.
`timescale 1ns / 1ps

module spi_mbs_engine
    import spi_mbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  tick_in_t  tick_in,
    input  cfg_t      cfg,
    input  pol_upd_t  pol_upd,
    output tick_res_t res
);

    cmd_t       active_reg, active_next;
    logic       clock_level_reg, clock_level_next;
    logic       data_out_reg, data_out_next;
    logic       select_reg, select_next;
    logic [7:0] send_reg, send_next;
    logic [7:0] recv_reg, recv_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic       second_half_reg, second_half_next;
    logic [7:0] tick_reg, tick_next;
    logic       drive_reg, drive_next;
    logic       valid_next;

    logic [7:0] half_eff;
    logic [7:0] tick_inc;
    logic [3:0] bits_dec;
    logic       half_done;
    logic       last_bit;

    // A half period of zero behaves as one tick.
    assign half_eff  = (cfg.half_ticks == 8'd0) ? 8'd1 : cfg.half_ticks;
    assign tick_inc  = tick_reg + 8'd1;
    assign bits_dec  = bits_left_reg - 4'd1;
    assign half_done = (active_reg == CMD_SHIFT) && (tick_inc >= half_eff);
    assign last_bit  = half_done && second_half_reg && (bits_dec == 4'd0);

    always_comb begin
        active_next = active_reg;
        unique case (active_reg)
            CMD_SHIFT: begin
                if (last_bit) active_next = CMD_NONE;
            end
            CMD_NONE: begin
                if (tick_in.mode == CMD_SHIFT) active_next = CMD_SHIFT;
            end
            default: active_next = CMD_NONE;
        endcase
    end

    always_comb begin
        clock_level_next = clock_level_reg;
        data_out_next    = data_out_reg;
        select_next      = select_reg;
        send_next        = send_reg;
        recv_next        = recv_reg;
        bits_left_next   = bits_left_reg;
        second_half_next = second_half_reg;
        tick_next        = tick_reg;
        drive_next       = drive_reg;
        valid_next       = 1'b0;

        if (active_reg == CMD_SHIFT) begin
            tick_next = tick_inc;
            if (half_done) begin
                tick_next = 8'd0;
                if (!second_half_reg) begin
                    if (!cfg.phase) recv_next = {recv_reg[6:0], tick_in.miso};
                    if (cfg.phase && drive_reg) begin
                        data_out_next = ((send_reg & MSB_MASK) != 8'd0);
                    end
                    clock_level_next = cfg.polarity;
                    second_half_next = 1'b1;
                end else begin
                    if (cfg.phase) recv_next = {recv_reg[6:0], tick_in.miso};
                    send_next        = {send_reg[6:0], 1'b0};
                    bits_left_next   = bits_dec;
                    second_half_next = 1'b0;
                    if (bits_dec == 4'd0) begin
                        valid_next = 1'b1;
                    end else begin
                        // Next bit begins: leading SCK edge, MOSI update in phase 0.
                        if (!cfg.phase && drive_reg) begin
                            data_out_next = ((send_next & MSB_MASK) != 8'd0);
                        end
                        clock_level_next = ~cfg.polarity;
                    end
                end
            end
        end else begin
            case (tick_in.mode)
                CMD_SELECT: begin
                    clock_level_next = cfg.polarity;
                    select_next      = 1'b0;
                end
                CMD_RELEASE: begin
                    select_next = 1'b1;
                end
                CMD_SHIFT: begin
                    send_next      = tick_in.tx_byte;
                    drive_next     = tick_in.drive_out;
                    bits_left_next = BITS_PER_BYTE;
                    if (!cfg.phase && tick_in.drive_out) begin
                        data_out_next = ((tick_in.tx_byte & MSB_MASK) != 8'd0);
                    end
                    clock_level_next = ~cfg.polarity;
                    second_half_next = 1'b0;
                    tick_next        = 8'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= CMD_NONE;
            clock_level_reg <= 1'b0;
            data_out_reg    <= 1'b0;
            select_reg      <= 1'b1;
            send_reg        <= 8'd0;
            recv_reg        <= 8'd0;
            bits_left_reg   <= 4'd0;
            second_half_reg <= 1'b0;
            tick_reg        <= 8'd0;
            drive_reg       <= 1'b0;
        end else if (step) begin
            active_reg      <= active_next;
            clock_level_reg <= clock_level_next;
            data_out_reg    <= data_out_next;
            select_reg      <= select_next;
            send_reg        <= send_next;
            recv_reg        <= recv_next;
            bits_left_reg   <= bits_left_next;
            second_half_reg <= second_half_next;
            tick_reg        <= tick_next;
            drive_reg       <= drive_next;
        end else if (pol_upd.wr && (active_reg == CMD_NONE)) begin
            clock_level_reg <= pol_upd.level;
        end
    end

    // The result shows the line levels after this tick.
    assign res.sck      = clock_level_next;
    assign res.mosi     = data_out_next;
    assign res.cs_n     = select_next;
    assign res.rx_byte  = recv_next;
    assign res.rx_valid = valid_next;
    assign res.busy_res = (active_next != CMD_NONE);

endmodule

@@ hw/rtl/spi_master_byte_shifter_top.sv @@
// Top level of the pin-level SPI master byte shifter, modes 0 to 3.
//
//   Channel | Direction | Handshake           | Payload
//   s_      | in        | s_valid / s_ready   | mode, tx_byte, drive_out, miso (one tick)
//   m_      | out       | m_valid / m_ready   | sck, mosi, cs_n, rx_byte, rx_valid, busy_res
//   cfg_    | in        | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// Each transfer in is one tick and yields one transfer out, by way of an input register,
// the update logic, then the result register.
// One transfer is taken every cycle while the result side keeps up; a stalled
// result register holds its transfer and stops the input register behind it.
// Reset is synchronous and active low and leaves chip select released.
`timescale 1ns / 1ps

module spi_master_byte_shifter_top
    import spi_mbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [7:0]            s_tx_byte,
    input  logic                  s_drive_out,
    input  logic                  s_miso,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_sck,
    output logic                  m_mosi,
    output logic                  m_cs_n,
    output logic [7:0]            m_rx_byte,
    output logic                  m_rx_valid,
    output logic                  m_busy_res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      in_valid_reg;
    tick_in_t  in_reg;
    logic      out_valid_reg;
    tick_res_t out_reg;
    logic      step;
    cfg_t      cfg;
    pol_upd_t  pol_upd;
    tick_res_t res;

    // A tick is processed when the result register is empty or being drained.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg.mode      <= cmd_t'(s_mode);
            in_reg.tx_byte   <= s_tx_byte;
            in_reg.drive_out <= s_drive_out;
            in_reg.miso      <= s_miso;
        end
    end

    spi_mbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .pol_upd   (pol_upd)
    );

    spi_mbs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .tick_in (in_reg),
        .cfg     (cfg),
        .pol_upd (pol_upd),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_sck      = out_reg.sck;
    assign m_mosi     = out_reg.mosi;
    assign m_cs_n     = out_reg.cs_n;
    assign m_rx_byte  = out_reg.rx_byte;
    assign m_rx_valid = out_reg.rx_valid;
    assign m_busy_res = out_reg.busy_res;

endmodule

@@ hw/rtl/spi_mbs_checker.sv @@
// Port-level checker of the SPI master byte shifter, bound to the top level.
`timescale 1ns / 1ps
`include "spi_master_byte_shifter_top_assert.svh"

module spi_mbs_assert_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_sck,
    input logic       m_cs_n,
    input logic [7:0] m_rx_byte,
    input logic       m_rx_valid,
    input logic       m_busy_res
);

    // A completed byte always ends the shift in the same transfer.
    `SPI_MBS_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_valid && m_rx_valid, !m_busy_res)

    // With no result pending the input side can never be held off.
    `SPI_MBS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    `SPI_MBS_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_rx_byte) && $stable(m_sck) && $stable(m_cs_n))

    `SPI_MBS_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind spi_master_byte_shifter_top spi_mbs_assert_checker u_spi_mbs_checker (.*);

@@ tb/sv/spi_mbs_checker.sv @@
// Checker that predicts and compares every result transfer of the SPI master byte shifter.
`timescale 1ns / 1ps

module spi_mbs_checker
    import spi_mbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [7:0]            s_tx_byte,
    input  logic                  s_drive_out,
    input  logic                  s_miso,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_sck,
    input  logic                  m_mosi,
    input  logic                  m_cs_n,
    input  logic [7:0]            m_rx_byte,
    input  logic                  m_rx_valid,
    input  logic                  m_busy_res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned           fail_count,
    output int unsigned           pending_count
);

    // Configuration as last written.
    logic       cfg_pol;
    logic       cfg_pha;
    logic [7:0] cfg_half;

    // Our own copy of the master's state.
    logic       sck_lvl;
    logic       mosi_lvl;
    logic       cs_lvl;
    logic [7:0] tx_sr;
    logic [7:0] rx_sr;
    logic [3:0] bits_left;
    logic       in_second;
    logic [7:0] half_ticks;
    cmd_t       run_cmd;
    logic       drive_en;

    tick_res_t  pending_levels[$];

    task automatic start_bit();
        if (!cfg_pha && drive_en) begin
            mosi_lvl = ((tx_sr & MSB_MASK) != 8'd0);
        end
        sck_lvl    = ~cfg_pol;
        in_second  = 1'b0;
        half_ticks = 8'd0;
    endtask

    task automatic advance_master(input tick_in_t t, output tick_res_t r);
        logic [7:0] half;
        logic       done;
        half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
        done = 1'b0;
        if (run_cmd == CMD_SHIFT) begin
            half_ticks = half_ticks + 8'd1;
            if (half_ticks >= half) begin
                half_ticks = 8'd0;
                if (!in_second) begin
                    if (!cfg_pha) begin
                        rx_sr = {rx_sr[6:0], t.miso};
                    end else if (drive_en) begin
                        mosi_lvl = ((tx_sr & MSB_MASK) != 8'd0);
                    end
                    sck_lvl   = cfg_pol;
                    in_second = 1'b1;
                end else begin
                    if (cfg_pha) begin
                        rx_sr = {rx_sr[6:0], t.miso};
                    end
                    tx_sr     = tx_sr << 1;
                    bits_left = bits_left - 4'd1;
                    in_second = 1'b0;
                    if (bits_left == 4'd0) begin
                        run_cmd = CMD_NONE;
                        done    = 1'b1;
                    end else begin
                        start_bit();
                    end
                end
            end
        end else begin
            // Commands are only looked at while no shift is running.
            case (t.mode)
                CMD_SELECT: begin
                    sck_lvl = cfg_pol;
                    cs_lvl  = 1'b0;
                end
                CMD_RELEASE: begin
                    cs_lvl = 1'b1;
                end
                CMD_SHIFT: begin
                    tx_sr     = t.tx_byte;
                    drive_en  = t.drive_out;
                    bits_left = BITS_PER_BYTE;
                    run_cmd   = CMD_SHIFT;
                    start_bit();
                end
                default: ;
            endcase
        end
        r.sck      = sck_lvl;
        r.mosi     = mosi_lvl;
        r.cs_n     = cs_lvl;
        r.rx_byte  = rx_sr;
        r.rx_valid = done;
        r.busy_res = (run_cmd != CMD_NONE);
    endtask

    always @(posedge aclk) begin
        tick_in_t  t;
        tick_res_t want;
        tick_res_t got;
        if (!aresetn) begin
            cfg_pol    = 1'b0;
            cfg_pha    = 1'b0;
            cfg_half   = HALF_TICKS_RST;
            sck_lvl    = 1'b0;
            mosi_lvl   = 1'b0;
            cs_lvl     = 1'b1;
            tx_sr      = 8'd0;
            rx_sr      = 8'd0;
            bits_left  = 4'd0;
            in_second  = 1'b0;
            half_ticks = 8'd0;
            run_cmd    = CMD_NONE;
            drive_en   = 1'b0;
            fail_count = 0;
            pending_levels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POLARITY: begin
                        cfg_pol = cfg_wdata[0];
                        // An idle clock line follows the new polarity at once.
                        if (run_cmd == CMD_NONE) begin
                            sck_lvl = cfg_pol;
                        end
                    end
                    REG_PHASE:      cfg_pha  = cfg_wdata[0];
                    REG_HALF_TICKS: cfg_half = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                t.mode      = cmd_t'(s_mode);
                t.tx_byte   = s_tx_byte;
                t.drive_out = s_drive_out;
                t.miso      = s_miso;
                advance_master(t, want);
                pending_levels.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.sck      = m_sck;
                got.mosi     = m_mosi;
                got.cs_n     = m_cs_n;
                got.rx_byte  = m_rx_byte;
                got.rx_valid = m_rx_valid;
                got.busy_res = m_busy_res;
                if (pending_levels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result transfer with none expected: sck=%b mosi=%b cs_n=%b rx_byte=%h rx_valid=%b busy=%b",
                                 $realtime, got.sck, got.mosi, got.cs_n, got.rx_byte,
                                 got.rx_valid, got.busy_res);
                    end
                end else begin
                    want = pending_levels.pop_front();
                    if (got.sck !== want.sck || got.mosi !== want.mosi ||
                        got.cs_n !== want.cs_n || got.rx_byte !== want.rx_byte ||
                        got.rx_valid !== want.rx_valid || got.busy_res !== want.busy_res) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected sck=%b mosi=%b cs_n=%b rx_byte=%h rx_valid=%b busy=%b",
                                     $realtime, want.sck, want.mosi, want.cs_n, want.rx_byte,
                                     want.rx_valid, want.busy_res);
                            $display("%0t:           actual sck=%b mosi=%b cs_n=%b rx_byte=%h rx_valid=%b busy=%b",
                                     $realtime, got.sck, got.mosi, got.cs_n, got.rx_byte,
                                     got.rx_valid, got.busy_res);
                        end
                    end
                end
            end
        end
        pending_count = pending_levels.size();
    end

endmodule

@@ tb/sv/tb_spi_master_byte_shifter_top.sv @@
// Testbench top for the SPI master byte shifter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_spi_master_byte_shifter_top;
    import spi_mbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_mode;
    logic [7:0]            s_tx_byte;
    logic                  s_drive_out;
    logic                  s_miso;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_sck;
    logic                  m_mosi;
    logic                  m_cs_n;
    logic [7:0]            m_rx_byte;
    logic                  m_rx_valid;
    logic                  m_busy_res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int unsigned           fail_count;
    int unsigned           pending_count;

    bit                    send_gaps;
    int unsigned           ticks_sent;

    spi_master_byte_shifter_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_tx_byte   (s_tx_byte),
        .s_drive_out (s_drive_out),
        .s_miso      (s_miso),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sck       (m_sck),
        .m_mosi      (m_mosi),
        .m_cs_n      (m_cs_n),
        .m_rx_byte   (m_rx_byte),
        .m_rx_valid  (m_rx_valid),
        .m_busy_res  (m_busy_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    spi_mbs_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_tx_byte     (s_tx_byte),
        .s_drive_out   (s_drive_out),
        .s_miso        (s_miso),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sck         (m_sck),
        .m_mosi        (m_mosi),
        .m_cs_n        (m_cs_n),
        .m_rx_byte     (m_rx_byte),
        .m_rx_valid    (m_rx_valid),
        .m_busy_res    (m_busy_res),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, none while the input side runs without gaps,
    // and one long hold-off that backs the block up until it stops taking
    // input transfers.
    initial begin : receiver
        int unsigned cyc;
        int unsigned hold;
        cyc    = 0;
        hold   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc == 450) begin
                hold = 300;
            end
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!send_gaps) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic put_tick(input cmd_t mode, input logic [7:0] tx, input logic drv,
                            input logic mi);
        while (send_gaps && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_tx_byte   <= tx;
        s_drive_out <= drv;
        s_miso      <= mi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Ticks with random MISO; noise_pct of them carry a random command.
    task automatic idle_ticks(input int unsigned n, input int unsigned noise_pct);
        cmd_t m;
        for (int unsigned i = 0; i < n; i++) begin
            m = CMD_NONE;
            if ($urandom_range(99) < noise_pct) begin
                m = cmd_t'($urandom_range(3));
            end
            put_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
    endtask

    // Select, a few byte shifts, release. The gap after each shift sometimes
    // ends on the completing tick, where the next command is dropped.
    task automatic run_frame(input int unsigned half, input int unsigned max_bytes);
        int unsigned nbytes;
        logic [7:0]  tx;
        int unsigned pick;
        if ($urandom_range(99) < 85) begin
            put_tick(CMD_SELECT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
        nbytes = $urandom_range(max_bytes, 1);
        for (int unsigned b = 0; b < nbytes; b++) begin
            pick = $urandom_range(9);
            tx = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
            put_tick(CMD_SHIFT, tx, ($urandom_range(99) < 80), 1'($urandom_range(1)));
            idle_ticks(16 * half - 1, 10);
            idle_ticks($urandom_range(2), 0);
        end
        if ($urandom_range(99) < 90) begin
            put_tick(CMD_RELEASE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
        idle_ticks($urandom_range(3), 0);
    endtask

    // Stops the input side and waits until every result transfer is back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic pol, input logic pha, input logic [7:0] half,
                             input int unsigned target, input int unsigned max_bytes,
                             input bit gaps, input bit end_busy);
        int unsigned first;
        int unsigned eff;
        drain_results();
        write_reg(REG_POLARITY, {7'd0, pol});
        write_reg(REG_PHASE, {7'd0, pha});
        write_reg(REG_HALF_TICKS, half);
        send_gaps = gaps;
        eff   = (half == 8'd0) ? 1 : 32'(half);
        first = ticks_sent;
        // A shift may still be running from before the write.
        idle_ticks(16 * eff, 5);
        while (ticks_sent - first < target) begin
            run_frame(eff, max_bytes);
        end
        idle_ticks(15, 100);
        if (end_busy) begin
            put_tick(CMD_SELECT, 8'h00, 1'b0, 1'b0);
            put_tick(CMD_SHIFT, 8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
            idle_ticks(4, 0);
        end
    endtask

    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_mode      = CMD_NONE;
        s_tx_byte   = 8'd0;
        s_drive_out = 1'b0;
        s_miso      = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_POLARITY;
        cfg_wdata   = 8'd0;
        send_gaps   = 1'b1;
        ticks_sent  = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one full byte with reset settings, a command while busy,
        // a command on the completing tick, and a shift without select that
        // is still running when the registers are next written.
        put_tick(CMD_SELECT, 8'h00, 1'b0, 1'b0);
        put_tick(CMD_SHIFT, 8'hA5, 1'b1, 1'b1);
        for (int i = 0; i < 15; i++) begin
            put_tick((i == 3) ? CMD_RELEASE : CMD_NONE, 8'hFF, 1'b1, i[0]);
        end
        put_tick(CMD_SHIFT, 8'h00, 1'b0, 1'b1);
        put_tick(CMD_RELEASE, 8'h00, 1'b0, 1'b0);
        put_tick(CMD_SHIFT, 8'h5A, 1'b0, 1'b1);
        idle_ticks(3, 0);

        run_phase(1'b1, 1'b0, 8'd1, 40, 2, 1'b1, 1'b0);
        run_phase(1'b0, 1'b0, 8'd2, 40, 1, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 8'd1, 40, 2, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 8'd3, 50, 1, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 8'd0, 20, 2, 1'b1, 1'b1);
        run_phase(1'b0, 1'b0, 8'd1, 20, 2, 1'b1, 1'b0);

        drain_results();
        repeat (4) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
